// ----- rtl/sbrm_pkg.sv -----
// sbrm_pkg: shared constants and controller/datapath interface types
// for the smoothed block RMS meter. No dependencies.
package sbrm_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int MAX_BLOCK_DEF    = 4096;

    localparam int SAMPLE_PORT_W = 24;
    localparam int COEFF_W       = 16;
    localparam int LEVEL_W       = 24;
    localparam int LEVEL_Q_W     = 32;
    localparam int LEVEL_FRAC    = 8;
    localparam int ACC_MAX_W     = 64;

    localparam int MUL_A_W = COEFF_W + 1;
    localparam int MUL_B_W = LEVEL_Q_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = MUL_P_W + LEVEL_FRAC + 1;

    localparam logic [MUL_A_W-1:0] BETA_ONE   = MUL_A_W'(1 << COEFF_W);
    localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1 << (COEFF_W - 1));

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic div_step;
        logic sqrt_step;
        logic mul_a;
        logic mul_b;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic step_zero;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/sbrm_ctrl.sv -----
// sbrm_ctrl: sequencer for accumulate, divide, square root and smoothing.
// Depends on sbrm_pkg (t_cmd, t_status).
module sbrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sbrm_pkg::t_status i_status,
    output sbrm_pkg::t_cmd    o_cmd
);
    import sbrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DIV,
        S_SQRT,
        S_MUL_A,
        S_MUL_B,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.accumulate = 1'b1;
                n_state          = i_status.last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_zero) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.step_zero) begin
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");

    a_add_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == S_ADD && !r_ready)
        else $error("capture not followed by accumulate");

    a_update_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> i_status.out_free)
        else $error("update with output register busy");

endmodule

// ----- rtl/sbrm_datapath.sv -----
// sbrm_datapath: square/accumulate, restoring divider, digit-by-digit root,
// shared smoothing multiplier and output register. Depends on sbrm_pkg.
module sbrm_datapath #(
    parameter int SAMPLE_WIDTH = sbrm_pkg::SAMPLE_WIDTH_DEF,
    parameter int MAX_BLOCK    = sbrm_pkg::MAX_BLOCK_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic signed [sbrm_pkg::SAMPLE_PORT_W-1:0] i_sample,
    input  logic                                     i_block_end,
    input  logic                                     i_coeff_we,
    input  logic [sbrm_pkg::COEFF_W-1:0]             i_coeff_wdata,
    input  sbrm_pkg::t_cmd                           i_cmd,
    output sbrm_pkg::t_status                        o_status,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [sbrm_pkg::LEVEL_W-1:0]             o_level,
    output logic                                     o_overflow
);
    import sbrm_pkg::*;

    localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
    localparam int ACC_RAW  = 2 * SAMPLE_WIDTH - 1 + CNT_W;
    localparam int ACC_EVEN = ACC_RAW + (ACC_RAW % 2);
    localparam int ACC_W    = (ACC_EVEN > ACC_MAX_W) ? ACC_MAX_W : ACC_EVEN;
    localparam int RMS_W    = ACC_W / 2;
    localparam int SREM_W   = RMS_W + 2;
    localparam int STEP_W   = $clog2(ACC_W);
    localparam int SQ_W     = 2 * SAMPLE_WIDTH;

    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_BLOCK);
    localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(ACC_W - 1);
    localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(RMS_W - 1);

    // sample magnitude and square
    logic [SAMPLE_WIDTH-1:0] w_raw;
    logic [SAMPLE_WIDTH-1:0] w_mag;
    logic [SQ_W-1:0]         w_sq;

    generate
        if (SAMPLE_WIDTH <= SAMPLE_PORT_W) begin : g_narrow
            assign w_raw = i_sample[SAMPLE_WIDTH-1:0];
        end else begin : g_wide
            assign w_raw = {{(SAMPLE_WIDTH - SAMPLE_PORT_W){1'b0}}, i_sample};
        end
    endgenerate

    assign w_mag = w_raw[SAMPLE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_sq  = {{SAMPLE_WIDTH{1'b0}}, w_mag} * {{SAMPLE_WIDTH{1'b0}}, w_mag};

    logic [ACC_W-1:0] r_sq;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sq   <= ACC_W'(w_sq);
            r_last <= i_block_end;
        end
    end

    // block accumulator; doubles as divider dividend/quotient and root radicand
    logic [ACC_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_rem;
    logic [ACC_W:0]    w_add;
    logic [CNT_W:0]    w_dshift;
    logic              w_dge;
    logic [CNT_W:0]    w_ddiff;

    assign w_add    = {1'b0, r_sum} + {1'b0, r_sq};
    assign w_dshift = {r_rem, r_sum[ACC_W-1]};
    assign w_dge    = (w_dshift >= {1'b0, r_cnt});
    assign w_ddiff  = w_dshift - {1'b0, r_cnt};

    logic [RMS_W-1:0]  r_root;
    logic [SREM_W-1:0] r_srem;
    logic [STEP_W-1:0] r_step;
    logic [SREM_W-1:0] w_cand;
    logic [SREM_W-1:0] w_trial;
    logic              w_sge;

    assign w_cand  = {r_srem[RMS_W-1:0], r_sum[ACC_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_sge   = (w_cand >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accumulate) begin
            if (r_cnt == CNT_MAX) begin
                r_ovf <= 1'b1;
            end else begin
                r_sum <= w_add[ACC_W] ? '1 : w_add[ACC_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_cmd.div_step) begin
            r_sum <= {r_sum[ACC_W-2:0], w_dge};
        end else if (i_cmd.sqrt_step) begin
            r_sum <= {r_sum[ACC_W-3:0], 2'b00};
        end else if (i_cmd.update) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accumulate) begin
            r_rem  <= '0;
            r_step <= DIV_STEPS;
        end else if (i_cmd.div_step) begin
            r_rem <= w_dge ? w_ddiff[CNT_W-1:0] : w_dshift[CNT_W-1:0];
            if (r_step == '0) begin
                r_step <= SQRT_STEPS;
                r_root <= '0;
                r_srem <= '0;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end else if (i_cmd.sqrt_step) begin
            r_srem <= w_sge ? (w_cand - w_trial) : w_cand;
            r_root <= {r_root[RMS_W-2:0], w_sge};
            r_step <= r_step - 1'b1;
        end
    end

    // smoothing: one shared 17x32 multiplier, two passes
    logic [COEFF_W-1:0]   r_coeff;
    logic [LEVEL_Q_W-1:0] r_level_q;
    logic [MUL_P_W-1:0]   r_prod_a;
    logic [MUL_P_W-1:0]   r_prod_b;
    logic [MUL_A_W-1:0]   w_mul_a;
    logic [MUL_B_W-1:0]   w_mul_b;
    logic [MUL_P_W-1:0]   w_prod;
    logic [SUM_W-1:0]     w_upd;
    logic [LEVEL_Q_W-1:0] w_new;

    always_comb begin
        if (i_cmd.mul_b) begin
            w_mul_a = BETA_ONE - {1'b0, r_coeff};
            w_mul_b = MUL_B_W'(r_root);
        end else begin
            w_mul_a = {1'b0, r_coeff};
            w_mul_b = r_level_q;
        end
    end

    assign w_prod = {{MUL_B_W{1'b0}}, w_mul_a} * {{MUL_A_W{1'b0}}, w_mul_b};
    assign w_upd  = SUM_W'(r_prod_a) + SUM_W'({r_prod_b, {LEVEL_FRAC{1'b0}}}) + ROUND_HALF;
    assign w_new  = w_upd[COEFF_W +: LEVEL_Q_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) begin
            r_prod_a <= w_prod;
        end
        if (i_cmd.mul_b) begin
            r_prod_b <= w_prod;
        end
    end

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff     <= '0;
            r_level_q   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_coeff_we) begin
                r_coeff <= i_coeff_wdata;
            end
            if (i_cmd.update) begin
                r_level_q   <= w_new;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_level    <= w_new[LEVEL_FRAC +: LEVEL_W];
            o_overflow <= r_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.last      = r_last;
    assign o_status.step_zero = (r_step == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("sample count beyond block limit");

    a_ovf_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_cnt == CNT_MAX)
        else $error("overflow flag without saturated count");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_rem < r_cnt)
        else $error("divider remainder not below divisor");

    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> r_cnt == '0 && !r_ovf && r_out_valid)
        else $error("block state not cleared after result");

endmodule

// ----- rtl/smoothed_block_rms_meter_top.sv -----
// smoothed_block_rms_meter_top: top level of the smoothed block RMS meter.
// Depends on sbrm_pkg, sbrm_ctrl, sbrm_datapath.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------
//  input    | i_in_valid / o_in_ready      | i_sample, i_block_end
//  output   | o_out_valid / i_out_ready    | o_level, o_overflow
//  coeff    | i_coeff_we (no wait)         | i_coeff_wdata
//
// A sample that does not end a block is captured and squared, then
// accumulated. A block-end beat is also accumulated, then runs
// ACC_W one-bit divider steps, ACC_W/2 root steps and three smoothing
// states (two passes on the shared multiplier, then the update).
// ACC_W is 2*SAMPLE_WIDTH-1 plus count bits, rounded up to even, at most 64.
// Synchronous active-low reset; no clearing pass. A result beat stalled at
// the output holds only the final smoothing cycle of the next block end.
module smoothed_block_rms_meter_top #(
    parameter int SAMPLE_WIDTH = sbrm_pkg::SAMPLE_WIDTH_DEF,
    parameter int MAX_BLOCK    = sbrm_pkg::MAX_BLOCK_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic signed [sbrm_pkg::SAMPLE_PORT_W-1:0] i_sample,
    input  logic                                     i_block_end,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [sbrm_pkg::LEVEL_W-1:0]             o_level,
    output logic                                     o_overflow,
    input  logic                                     i_coeff_we,
    input  logic [sbrm_pkg::COEFF_W-1:0]             i_coeff_wdata
);
    import sbrm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sbrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sbrm_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_BLOCK    (MAX_BLOCK)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (i_sample),
        .i_block_end   (i_block_end),
        .i_coeff_we    (i_coeff_we),
        .i_coeff_wdata (i_coeff_wdata),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_level       (o_level),
        .o_overflow    (o_overflow)
    );

endmodule
